FILE: rtl/grid_free_energy_density_sum_core_assert.svh
// assertion macros for the free energy density core
`ifndef GRID_FREE_ENERGY_DENSITY_SUM_CORE_ASSERT_SVH
`define GRID_FREE_ENERGY_DENSITY_SUM_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define GFEDS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define GFEDS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gfeds_pkg.sv
// shared types, constants and fixed point helpers of the free energy density core
`default_nettype none

package gfeds_pkg;

    localparam int unsigned OUT_TDATA_W = 120;

    localparam logic signed [47:0] SAT_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_LO = 48'sh8000_0000_0000;

    // 0.3 and 0.7 in q16.16
    localparam logic signed [32:0] Q_CA = 33'sd19661;
    localparam logic signed [32:0] Q_CB = 33'sd45875;

    localparam logic [10:0] RST_GRID_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_GRID_HEIGHT = 11'd1024;
    localparam logic [1:0]  RST_MARGIN      = 2'd1;
    localparam logic [31:0] RST_KAPPA       = 32'd65536;
    localparam logic [30:0] RST_GRAD_WEIGHT = 31'd16384;
    localparam logic [30:0] RST_CELL_VOLUME = 31'd65536;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH    = 3'd0,
        REG_GRID_HEIGHT   = 3'd1,
        REG_MARGIN        = 3'd2,
        REG_KAPPA         = 3'd3,
        REG_GRAD_X_WEIGHT = 3'd4,
        REG_GRAD_Y_WEIGHT = 3'd5,
        REG_CELL_VOLUME   = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_A2   = 4'd0,
        ST_B2   = 4'd1,
        ST_CHEM = 4'd2,
        ST_DX2  = 4'd3,
        ST_GX   = 4'd4,
        ST_DY2  = 4'd5,
        ST_GY   = 4'd6,
        ST_KG   = 4'd7,
        ST_E    = 4'd8
    } t_step;

    typedef struct packed {
        logic               start;
        logic signed [47:0] op_a;
        logic signed [47:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [47:0] prod;
    } t_mul_rsp;

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v > 51'(SAT_HI)) begin
            r = SAT_HI;
        end else if (v < 51'(SAT_LO)) begin
            r = SAT_LO;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // product with 0.5, rounded half away from zero
    function automatic logic signed [47:0] q_half(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [48:0] inc;
        logic [47:0] hm;
        mag = v[47] ? (~v[47:0] + 48'd1) : v[47:0];
        inc = {1'b0, mag} + 49'd1;
        hm  = inc[48:1];
        return v[47] ? (~hm + 48'd1) : hm;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/grid_free_energy_density_sum_core.sv
// top level of the streaming cahn-hilliard free energy density and sum core
//
// concentration samples (signed q16.16) enter in raster order on the s_axis
// channel, one per transfer. each sample completes the five point stencil of
// the cell one row above it; when that cell lies inside the margin, one result
// leaves on m_axis with the local energy, the cell position, the saturated
// running sum and tlast on the final interior cell of the grid.
// the apb port sets grid size, margin, kappa, gradient weights and cell
// volume; write it only while no sample is in flight.
// the previous two rows sit in one row memory (one read per cell at the
// center column and one at the right neighbor, one write back per sample).
// an interior cell is computed by nine products in turn through one shared
// multiplier. a finished result waits in the output register while the next
// sample is taken; a stalled receiver holds the core before its next result
// only. reset clears counters, window, running sum and the registers to their
// defaults; the row memory needs no clearing, entries are written before use.
`default_nettype none

module grid_free_energy_density_sum_core
    import gfeds_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // conc
    input  wire logic [31:0]            s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // energy_density, cell_col, cell_row, total_energy, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // last_cell
    output logic                        m_axis_tlast,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    `include "grid_free_energy_density_sum_core_assert.svh"

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WXW = $clog2(MAX_WIDTH + 1);
    localparam int HXW = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = (WXW > 11) ? WXW : 11;
    localparam int YW  = (HXW > 11) ? HXW : 11;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_ACC   = 5'b10000
    } t_state;

    // configuration registers
    logic [10:0]        r_grid_width;
    logic [10:0]        r_grid_height;
    logic [1:0]         r_margin;
    logic signed [31:0] r_kappa;
    logic [30:0]        r_grad_x_weight;
    logic [30:0]        r_grad_y_weight;
    logic [30:0]        r_cell_volume;

    t_state             r_state;
    t_step              r_step;
    t_step              step_next;
    logic [CW-1:0]      r_col_cnt;
    logic [RW-1:0]      r_row_cnt;
    logic signed [47:0] r_acc;
    logic [31:0]        r_left;

    logic [63:0]        r_mem [MAX_WIDTH];
    logic [63:0]        r_rd_x;
    logic [63:0]        r_rd_x1;
    logic [CW-1:0]      r_addr;
    logic [31:0]        r_raw;
    logic               r_interior;
    logic               r_last_flag;
    logic [9:0]         r_out_col;
    logic [9:0]         r_out_row;

    logic signed [32:0] r_ca;
    logic signed [32:0] r_cb;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic signed [47:0] r_ta;
    logic signed [47:0] r_tb;
    logic signed [47:0] r_chem;
    logic signed [47:0] r_g;
    logic signed [47:0] r_s;
    logic signed [47:0] r_e;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_last;

    t_reg_idx           cfg_idx;
    logic               cfg_wr;
    logic               accept;
    logic               out_free;
    logic [XW-1:0]      gw_x;
    logic [XW-1:0]      w_eff;
    logic [YW-1:0]      gh_y;
    logic [YW-1:0]      h_eff;
    logic [1:0]         m_eff;
    logic [XW-1:0]      col_x;
    logic [XW-1:0]      col_hi;
    logic [YW-1:0]      row_y;
    logic [YW-1:0]      row_hi;
    logic               col_in;
    logic               row_in;
    logic               col_wrap;
    logic               row_wrap;
    logic               grid_end;
    logic [CW-1:0]      addr_x1;
    logic signed [31:0] v_mid;
    logic signed [31:0] v_up;
    logic signed [31:0] v_down;
    logic signed [31:0] v_left;
    logic signed [31:0] v_right;
    logic signed [47:0] total;
    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;

    // apb register file
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width    <= RST_GRID_WIDTH;
            r_grid_height   <= RST_GRID_HEIGHT;
            r_margin        <= RST_MARGIN;
            r_kappa         <= RST_KAPPA;
            r_grad_x_weight <= RST_GRAD_WEIGHT;
            r_grad_y_weight <= RST_GRAD_WEIGHT;
            r_cell_volume   <= RST_CELL_VOLUME;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:    r_grid_width    <= pwdata[10:0];
                REG_GRID_HEIGHT:   r_grid_height   <= pwdata[10:0];
                REG_MARGIN:        r_margin        <= pwdata[1:0];
                REG_KAPPA:         r_kappa         <= pwdata;
                REG_GRAD_X_WEIGHT: r_grad_x_weight <= pwdata[30:0];
                REG_GRAD_Y_WEIGHT: r_grad_y_weight <= pwdata[30:0];
                REG_CELL_VOLUME:   r_cell_volume   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:    prdata = {21'd0, r_grid_width};
            REG_GRID_HEIGHT:   prdata = {21'd0, r_grid_height};
            REG_MARGIN:        prdata = {30'd0, r_margin};
            REG_KAPPA:         prdata = r_kappa;
            REG_GRAD_X_WEIGHT: prdata = {1'b0, r_grad_x_weight};
            REG_GRAD_Y_WEIGHT: prdata = {1'b0, r_grad_y_weight};
            REG_CELL_VOLUME:   prdata = {1'b0, r_cell_volume};
            default:           prdata = 32'd0;
        endcase
    end

    // effective grid geometry
    assign gw_x  = XW'(r_grid_width);
    assign gh_y  = YW'(r_grid_height);
    assign w_eff = (gw_x < XW'(3)) ? XW'(3)
                                   : ((gw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : gw_x);
    assign h_eff = (gh_y < YW'(3)) ? YW'(3)
                                   : ((gh_y > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : gh_y);

    always_comb begin
        case (r_margin)
            2'd0:    m_eff = 2'd1;
            2'd3:    m_eff = 2'd2;
            default: m_eff = r_margin;
        endcase
    end

    assign col_x    = XW'(r_col_cnt);
    assign row_y    = YW'(r_row_cnt);
    assign col_hi   = w_eff - XW'(1) - XW'(m_eff);
    assign row_hi   = h_eff - YW'(m_eff);
    assign col_in   = (col_x >= XW'(m_eff)) && (col_x <= col_hi);
    assign row_in   = (row_y > YW'(m_eff)) && (row_y <= row_hi);
    assign col_wrap = col_x >= (w_eff - XW'(1));
    assign row_wrap = row_y >= (h_eff - YW'(1));
    assign grid_end = col_wrap && row_wrap;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign addr_x1 = (r_col_cnt == CW'(MAX_WIDTH - 1)) ? '0 : (r_col_cnt + CW'(1));

    // row memory: [63:32] older row, [31:0] newer row
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_x  <= r_mem[r_col_cnt];
            r_rd_x1 <= r_mem[addr_x1];
        end
        if (r_state == S_LOAD) begin
            r_mem[r_addr] <= {r_rd_x[31:0], r_raw};
        end
    end

    assign v_mid   = r_rd_x[31:0];
    assign v_up    = r_rd_x[63:32];
    assign v_right = r_rd_x1[31:0];
    assign v_down  = r_raw;
    assign v_left  = r_left;

    always_comb begin
        case (r_step)
            ST_A2:   step_next = ST_B2;
            ST_B2:   step_next = ST_CHEM;
            ST_CHEM: step_next = ST_DX2;
            ST_DX2:  step_next = ST_GX;
            ST_GX:   step_next = ST_DY2;
            ST_DY2:  step_next = ST_GY;
            ST_GY:   step_next = ST_KG;
            ST_KG:   step_next = ST_E;
            default: step_next = ST_E;
        endcase
    end

    always_comb begin
        mul_req.start = (r_state == S_ISSUE);
        case (r_step)
            ST_A2: begin
                mul_req.op_a = 48'(r_ca);
                mul_req.op_b = 48'(r_ca);
            end
            ST_B2: begin
                mul_req.op_a = 48'(r_cb);
                mul_req.op_b = 48'(r_cb);
            end
            ST_CHEM: begin
                mul_req.op_a = r_ta;
                mul_req.op_b = r_tb;
            end
            ST_DX2: begin
                mul_req.op_a = 48'(r_dx);
                mul_req.op_b = 48'(r_dx);
            end
            ST_GX: begin
                mul_req.op_a = r_ta;
                mul_req.op_b = {17'd0, r_grad_x_weight};
            end
            ST_DY2: begin
                mul_req.op_a = 48'(r_dy);
                mul_req.op_b = 48'(r_dy);
            end
            ST_GY: begin
                mul_req.op_a = r_ta;
                mul_req.op_b = {17'd0, r_grad_y_weight};
            end
            ST_KG: begin
                mul_req.op_a = 48'(r_kappa);
                mul_req.op_b = r_g;
            end
            ST_E: begin
                mul_req.op_a = {17'd0, r_cell_volume};
                mul_req.op_b = r_s;
            end
            default: begin
                mul_req.op_a = '0;
                mul_req.op_b = '0;
            end
        endcase
    end

    gfeds_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign total = sat48(51'(r_acc) + 51'(r_e));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= ST_A2;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_acc     <= '0;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_ACC && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOAD;
                        if (col_wrap) begin
                            r_col_cnt <= '0;
                            if (row_wrap) begin
                                r_row_cnt <= '0;
                                r_acc     <= '0;
                            end else begin
                                r_row_cnt <= r_row_cnt + RW'(1);
                            end
                        end else begin
                            r_col_cnt <= r_col_cnt + CW'(1);
                        end
                    end
                end
                S_LOAD: begin
                    r_left  <= r_rd_x[31:0];
                    r_step  <= ST_A2;
                    r_state <= r_interior ? S_ISSUE : S_IDLE;
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_rsp.done) begin
                        if (r_step == ST_E) begin
                            r_state <= S_ACC;
                        end else begin
                            r_step  <= step_next;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ACC: begin
                    if (out_free) begin
                        r_acc   <= total;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw       <= s_axis_tdata;
            r_addr      <= r_col_cnt;
            r_interior  <= col_in && row_in;
            r_last_flag <= (col_x == col_hi) && (row_y == row_hi);
            r_out_col   <= 10'(r_col_cnt);
            r_out_row   <= 10'(r_row_cnt - RW'(1));
        end
        if (r_state == S_LOAD) begin
            r_ca <= 33'(v_mid) - Q_CA;
            r_cb <= Q_CB - 33'(v_mid);
            r_dx <= 33'(v_right) - 33'(v_left);
            r_dy <= 33'(v_down) - 33'(v_up);
        end
        if (r_state == S_WAIT && mul_rsp.done) begin
            case (r_step)
                ST_A2:   r_ta   <= mul_rsp.prod;
                ST_B2:   r_tb   <= mul_rsp.prod;
                ST_CHEM: r_chem <= sat48((51'(mul_rsp.prod) <<< 2) + 51'(mul_rsp.prod));
                ST_DX2:  r_ta   <= mul_rsp.prod;
                ST_GX:   r_tb   <= mul_rsp.prod;
                ST_DY2:  r_ta   <= mul_rsp.prod;
                ST_GY:   r_g    <= sat48(51'(r_tb) + 51'(mul_rsp.prod));
                ST_KG:   r_s    <= sat48(51'(r_chem) + 51'(q_half(mul_rsp.prod)));
                ST_E:    r_e    <= mul_rsp.prod;
                default: ;
            endcase
        end
        if (r_state == S_ACC && out_free) begin
            r_m_data <= {4'd0, total, r_out_row, r_out_col, r_e};
            r_m_last <= r_last_flag;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    `GFEDS_ASSERT_NEXT(a_accept_load, accept, r_state == S_LOAD, "transfer did not start a row update")
    `GFEDS_ASSERT_NEXT(a_acc_clear, accept && grid_end, r_acc == '0, "running sum not cleared at grid end")
    `GFEDS_ASSERT_SAME(a_mul_done_wait, mul_rsp.done, r_state == S_WAIT, "product done outside wait")
    `GFEDS_ASSERT_NEXT(a_result_loaded, (r_state == S_ACC) && out_free, m_axis_tvalid && (r_state == S_IDLE), "result not loaded")

endmodule

`default_nettype wire

FILE: rtl/gfeds_qmul.sv
// iterative q16.16 multiplier with rounding and 48 bit saturation
`default_nettype none

module gfeds_qmul
    import gfeds_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic [1:0]         r_phase;
    logic               r_neg;
    logic [47:0]        r_ua;
    logic [47:0]        r_ub;
    logic [95:0]        r_acc;
    logic signed [47:0] r_prod;

    logic [47:0]        mag_a;
    logic [47:0]        mag_b;
    logic [15:0]        chunk;
    logic [63:0]        pp;
    logic [95:0]        pp_sh;
    logic [79:0]        fin_mag;
    logic               fin_ovf;
    logic [47:0]        fin_val;

    assign mag_a = i_req.op_a[47] ? (~i_req.op_a[47:0] + 48'd1) : i_req.op_a[47:0];
    assign mag_b = i_req.op_b[47] ? (~i_req.op_b[47:0] + 48'd1) : i_req.op_b[47:0];

    always_comb begin
        case (r_phase)
            2'd0: chunk = r_ub[15:0];
            2'd1: chunk = r_ub[31:16];
            2'd2: chunk = r_ub[47:32];
            default: chunk = 16'd0;
        endcase
    end

    assign pp = r_ua * chunk;

    always_comb begin
        case (r_phase)
            2'd0: pp_sh = {32'd0, pp};
            2'd1: pp_sh = {16'd0, pp, 16'd0};
            2'd2: pp_sh = {pp, 32'd0};
            default: pp_sh = 96'd0;
        endcase
    end

    assign fin_mag = r_acc[95:16];
    assign fin_ovf = |fin_mag[79:47];
    assign fin_val = fin_ovf ? (r_neg ? SAT_LO : SAT_HI)
                             : (r_neg ? (~fin_mag[47:0] + 48'd1) : fin_mag[47:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_busy) begin
                if (r_phase == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua  <= mag_a;
            r_ub  <= mag_b;
            r_neg <= i_req.op_a[47] ^ i_req.op_b[47];
            // rounding half ulp preloaded
            r_acc <= 96'h8000;
        end else if (r_busy && r_phase != 2'd3) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_busy && r_phase == 2'd3) begin
            r_prod <= fin_val;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

`default_nettype wire
